// ===== src/rld_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the run-list decoder.
// No dependencies; the interfaces and the core import this package.
package rld_pkg;

   localparam int unsigned MAX_FIELD_BYTES = 8;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned WORD_W          = 64;
   localparam int unsigned COUNT_W         = 16;

   localparam logic [BYTE_W-1:0] END_OF_LIST_BYTE = 8'h00;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      STATUS_RUN = 2'd0,
      STATUS_END = 2'd1,
      STATUS_BAD = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PHASE_HEADER = 3'b001,
      PHASE_OFFSET = 3'b010,
      PHASE_LENGTH = 3'b100
   } phase_type;

endpackage

// ===== src/rld_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the run-list decoder.
// Depends on rld_pkg for payload types.
interface rld_req_if;
   import rld_pkg::*;

   logic     valid;
   logic     ready;
   byte_type stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rld_rsp_if;
   import rld_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   word_type   run_offset;
   word_type   run_length;
   count_type  runs_seen;

   modport source (output valid, output status, output run_offset, output run_length,
                   output runs_seen, input ready);
   modport sink   (input valid, input status, input run_offset, input run_length,
                   input runs_seen, output ready);
endinterface

// ===== src/run_list_decoder_core.sv =====
`timescale 1ns / 1ps
// Run-list decoder core: parses header and field bytes into absolute runs.
// Depends on rld_pkg and the channel interfaces in rld_if.sv.
//
// Usage:
//   req_chan carries one stream byte per transfer. A header byte gives the
//   delta-field size (high nibble) and length-field size (low nibble), each
//   1 to 8 bytes, little-endian. rsp_chan carries one result for each run
//   completed by its last length byte, for an end-of-list byte (0x00 in
//   header position) and for a malformed header; other bytes give no result.
//   Latency: a result is valid in the cycle after the byte that causes it.
//   Throughput: one byte per cycle while req_chan.ready is high. The offset
//   add is done when the last delta byte arrives and the next-base add when
//   the last length byte arrives, so each cycle holds a single 64-bit add.
//   A single output register holds the result; req_chan.ready drops only
//   while that register is full and rsp_chan.ready is low, and returns in
//   the same cycle the receiver takes the result.
//   Reset (synchronous, active high) empties the output register and starts
//   a new list with a zero base and a zero run count.
module run_list_decoder_core (
   input  logic         clock,
   input  logic         reset,
   rld_req_if.sink      req_chan,
   rld_rsp_if.source    rsp_chan
);
   import rld_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] bytes_left_ff, bytes_left_in;
   logic [2:0] byte_pos_ff, byte_pos_in;
   logic [3:0] pend_len_ff, pend_len_in;
   word_type   delta_ff, delta_in;
   word_type   length_ff, length_in;
   word_type   base_ff, base_in;
   count_type  count_ff, count_in;

   logic       rsp_valid_ff;
   status_type status_ff, status_in;
   word_type   run_offset_ff, run_offset_in;
   word_type   run_length_ff, run_length_in;
   count_type  runs_seen_ff, runs_seen_in;
   logic       emit;

   logic       accept;
   byte_type   in_byte;
   word_type   shifted;
   word_type   delta_merge;
   word_type   length_merge;
   logic [3:0] bytes_left_dec;
   logic [3:0] off_nibble;
   logic [3:0] len_nibble;
   logic       bad_header;
   count_type  count_inc;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_byte        = req_chan.stream_byte;

   assign shifted        = word_type'(in_byte) << {byte_pos_ff, 3'b000};
   assign delta_merge    = delta_ff | shifted;
   assign length_merge   = length_ff | shifted;
   assign bytes_left_dec = bytes_left_ff - 4'd1;
   assign off_nibble     = in_byte[7:4];
   assign len_nibble     = in_byte[3:0];
   assign bad_header     = (off_nibble == 4'd0) || (len_nibble == 4'd0)
                        || (off_nibble > 4'(MAX_FIELD_BYTES))
                        || (len_nibble > 4'(MAX_FIELD_BYTES));
   assign count_inc      = (count_ff == '1) ? count_ff : count_ff + count_type'(1);

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      byte_pos_in   = byte_pos_ff;
      pend_len_in   = pend_len_ff;
      delta_in      = delta_ff;
      length_in     = length_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      emit          = 1'b0;
      status_in     = STATUS_RUN;
      run_offset_in = '0;
      run_length_in = '0;
      runs_seen_in  = count_ff;

      unique case (phase_ff)
         PHASE_OFFSET: begin
            byte_pos_in   = byte_pos_ff + 3'd1;
            bytes_left_in = bytes_left_dec;
            if (bytes_left_dec != 4'd0) begin
               delta_in = delta_merge;
            end else begin
               // Delta complete: hold the absolute offset in the delta register
               phase_in      = PHASE_LENGTH;
               byte_pos_in   = 3'd0;
               bytes_left_in = pend_len_ff;
               delta_in      = base_ff + delta_merge;
            end
         end
         PHASE_LENGTH: begin
            byte_pos_in   = byte_pos_ff + 3'd1;
            bytes_left_in = bytes_left_dec;
            if (bytes_left_dec != 4'd0) begin
               length_in = length_merge;
            end else begin
               emit          = 1'b1;
               status_in     = STATUS_RUN;
               run_offset_in = delta_ff;
               run_length_in = length_merge;
               runs_seen_in  = count_inc;
               base_in       = delta_ff + length_merge;
               count_in      = count_inc;
               phase_in      = PHASE_HEADER;
               byte_pos_in   = 3'd0;
               delta_in      = '0;
               length_in     = '0;
               pend_len_in   = 4'd0;
            end
         end
         default: begin
            // Header position
            if (in_byte == END_OF_LIST_BYTE || bad_header) begin
               emit          = 1'b1;
               status_in     = (in_byte == END_OF_LIST_BYTE) ? STATUS_END : STATUS_BAD;
               phase_in      = PHASE_HEADER;
               bytes_left_in = 4'd0;
               byte_pos_in   = 3'd0;
               pend_len_in   = 4'd0;
               delta_in      = '0;
               length_in     = '0;
               base_in       = '0;
               count_in      = '0;
            end else begin
               phase_in      = PHASE_OFFSET;
               bytes_left_in = off_nibble;
               pend_len_in   = len_nibble;
               byte_pos_in   = 3'd0;
               delta_in      = '0;
               length_in     = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HEADER;
         bytes_left_ff <= 4'd0;
         byte_pos_ff   <= 3'd0;
         pend_len_ff   <= 4'd0;
         delta_ff      <= '0;
         length_ff     <= '0;
         base_ff       <= '0;
         count_ff      <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         byte_pos_ff   <= byte_pos_in;
         pend_len_ff   <= pend_len_in;
         delta_ff      <= delta_in;
         length_ff     <= length_in;
         base_ff       <= base_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result register only on a transfer that produces a result
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         status_ff     <= status_in;
         run_offset_ff <= run_offset_in;
         run_length_ff <= run_length_in;
         runs_seen_ff  <= runs_seen_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.run_offset = run_offset_ff;
   assign rsp_chan.run_length = run_length_ff;
   assign rsp_chan.runs_seen  = runs_seen_ff;

endmodule

// ===== tb/run_list_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for run_list_decoder_core: byte stream in, decoded runs out.
// Depends on rld_pkg, the channel interfaces in rld_if.sv and the core itself.
module run_list_decoder_core_tb;
   import rld_pkg::*;

   localparam int          CLOCK_HALF     = 6;
   localparam int unsigned CYCLE_LIMIT    = 100_000;
   localparam int unsigned HOLDOFF_CYCLES = 200;
   localparam int unsigned SETTLE_CYCLES  = 8;

   // empty list, max bytes, offset wrap, zero field byte, zero and oversized nibbles
   localparam byte_type DIRECTED [22] = '{
      8'h00,
      8'h11, 8'hFF, 8'hFF,
      8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
      8'h00,
      8'h10,
      8'h11, 8'h00, 8'h00, 8'h01,
      8'h91,
      8'h19
   };

   typedef struct packed {
      status_type status;
      word_type   run_offset;
      word_type   run_length;
      count_type  runs_seen;
   } run_result_type;

   logic clock = 1'b0;
   logic reset;

   rld_req_if req_chan ();
   rld_rsp_if rsp_chan ();

   run_list_decoder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   byte_type       stream_q [$];
   run_result_type decoded_q [$];
   run_result_type want;

   // predicted decoder state
   phase_type  dec_phase;
   logic [3:0] dec_left;
   logic [2:0] dec_pos;
   logic [3:0] dec_len_bytes;
   word_type   dec_delta;
   word_type   dec_len;
   word_type   dec_base;
   count_type  dec_count;

   int unsigned idle_pct;
   int unsigned src_gap;
   int unsigned sink_gap;
   int unsigned hold_left;
   int unsigned holdoff_req;
   int unsigned holdoff_done;
   int unsigned failures;
   int unsigned bytes_sent;
   int unsigned cycle_count;
   int unsigned runs_checked;
   int unsigned ends_checked;
   int unsigned bad_checked;

   always #CLOCK_HALF clock = ~clock;

   task automatic clear_list();
      dec_phase     = PHASE_HEADER;
      dec_left      = '0;
      dec_pos       = '0;
      dec_len_bytes = '0;
      dec_delta     = '0;
      dec_len       = '0;
      dec_base      = '0;
      dec_count     = '0;
   endtask

   task automatic push_result(input status_type st, input word_type off, input word_type len);
      decoded_q.push_back('{status: st, run_offset: off, run_length: len,
                            runs_seen: dec_count});
   endtask

   task automatic decode_byte(input byte_type b);
      logic [3:0] hi;
      logic [3:0] lo;
      word_type   start;
      hi = b[7:4];
      lo = b[3:0];
      if (dec_phase == PHASE_OFFSET || dec_phase == PHASE_LENGTH) begin
         if (dec_phase == PHASE_OFFSET)
            dec_delta |= word_type'(b) << (8 * dec_pos);
         else
            dec_len |= word_type'(b) << (8 * dec_pos);
         dec_pos++;
         dec_left--;
         if (dec_left == 0) begin
            dec_pos = '0;
            if (dec_phase == PHASE_OFFSET) begin
               dec_phase = PHASE_LENGTH;
               dec_left  = dec_len_bytes;
            end else begin
               start    = dec_base + dec_delta;
               dec_base = start + dec_len;
               if (dec_count != '1)
                  dec_count++;
               push_result(STATUS_RUN, start, dec_len);
               dec_phase     = PHASE_HEADER;
               dec_delta     = '0;
               dec_len       = '0;
               dec_len_bytes = '0;
            end
         end
      end else if (b == END_OF_LIST_BYTE) begin
         push_result(STATUS_END, '0, '0);
         clear_list();
      end else if (hi == 0 || lo == 0 || hi > MAX_FIELD_BYTES || lo > MAX_FIELD_BYTES) begin
         push_result(STATUS_BAD, '0, '0);
         clear_list();
      end else begin
         dec_phase     = PHASE_OFFSET;
         dec_left      = hi;
         dec_len_bytes = lo;
         dec_pos       = '0;
         dec_delta     = '0;
         dec_len       = '0;
      end
   endtask

   // field bytes lean toward the all-zero and all-one extremes
   function automatic byte_type field_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return byte_type'($urandom_range(255));
      endcase
   endfunction

   task automatic queue_random_lists(input int unsigned budget);
      int unsigned target;
      int unsigned dn;
      int unsigned ln;
      byte_type    b;
      target = stream_q.size() + budget;
      while (stream_q.size() < target) begin
         repeat ($urandom_range(0, 6)) begin
            dn = $urandom_range(1, MAX_FIELD_BYTES);
            ln = $urandom_range(1, MAX_FIELD_BYTES);
            stream_q.push_back(byte_type'((dn << 4) | ln));
            repeat (dn + ln) stream_q.push_back(field_byte());
         end
         case ($urandom_range(9))
            6: begin
               do begin
                  b = byte_type'($urandom_range(1, 255));
               end while (b[7:4] >= 1 && b[7:4] <= MAX_FIELD_BYTES &&
                          b[3:0] >= 1 && b[3:0] <= MAX_FIELD_BYTES);
               stream_q.push_back(b);
            end
            7: stream_q.push_back(byte_type'($urandom_range(255)));
            8: begin
               // cut a run short; the next list's bytes land in its fields
               dn = $urandom_range(1, MAX_FIELD_BYTES);
               ln = $urandom_range(1, MAX_FIELD_BYTES);
               stream_q.push_back(byte_type'((dn << 4) | ln));
               repeat ($urandom_range(0, dn + ln - 1)) stream_q.push_back(field_byte());
            end
            9: ;
            default: stream_q.push_back(END_OF_LIST_BYTE);
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (stream_q.size() != 0 || req_chan.valid || decoded_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.stream_byte <= '0;
         src_gap = 0;
         clear_list();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_byte(req_chan.stream_byte);
            stream_q.delete(0);
            bytes_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_chan.valid <= 1'b0;
            end else if (stream_q.size() > 0 && idle_pct > 0 &&
                         $urandom_range(99) < idle_pct) begin
               src_gap = $urandom_range(0, 8);
               req_chan.valid <= 1'b0;
            end else if (stream_q.size() > 0) begin
               req_chan.valid       <= 1'b1;
               req_chan.stream_byte <= stream_q[0];
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (decoded_q.size() == 0) begin
               failures++;
               $error("unexpected result: status %0d offset %h length %h runs_seen %0d",
                      rsp_chan.status, rsp_chan.run_offset, rsp_chan.run_length,
                      rsp_chan.runs_seen);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_chan.status !== want.status) begin
                  failures++;
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               end
               if (rsp_chan.run_offset !== want.run_offset) begin
                  failures++;
                  $error("run_offset: expected %h, got %h",
                         want.run_offset, rsp_chan.run_offset);
               end
               if (rsp_chan.run_length !== want.run_length) begin
                  failures++;
                  $error("run_length: expected %h, got %h",
                         want.run_length, rsp_chan.run_length);
               end
               if (rsp_chan.runs_seen !== want.runs_seen) begin
                  failures++;
                  $error("runs_seen: expected %0d, got %0d",
                         want.runs_seen, rsp_chan.runs_seen);
               end
               case (want.status)
                  STATUS_RUN: runs_checked++;
                  STATUS_END: ends_checked++;
                  default:    bad_checked++;
               endcase
            end
         end
         if (holdoff_req != holdoff_done) begin
            holdoff_done = holdoff_req;
            hold_left    = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            sink_gap = $urandom_range(0, 8);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, decoded_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      idle_pct    = 25;
      holdoff_req = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      foreach (DIRECTED[i]) stream_q.push_back(DIRECTED[i]);
      wait_drained();

      idle_pct = 30;
      queue_random_lists(350);
      wait_drained();

      // stall the receiver while bytes keep coming so the input backs up
      idle_pct = 0;
      holdoff_req++;
      queue_random_lists(80);
      wait_drained();

      idle_pct = 10;
      queue_random_lists(80);
      wait_drained();

      // closing stretch at full rate on both sides
      idle_pct = 0;
      queue_random_lists(130);
      wait_drained();

      $display("%0d stream bytes sent in %0d cycles, with idles and a long receiver stall",
               bytes_sent, cycle_count);
      $display("checked %0d runs, %0d list ends, %0d malformed headers",
               runs_checked, ends_checked, bad_checked);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
